// File: hdl/albt_pkg.sv
// shared types, constants, curve segment lookup and absolute difference helper for the backlight tracker
package albt_pkg;

  localparam int unsigned LUX_W = 16;
  localparam int unsigned BRT_W = 11;
  localparam int unsigned INC_W = 12;
  localparam int unsigned SUM_W = 20;
  localparam int unsigned DIV_W = 20;
  localparam int unsigned DVS_W = 9;
  localparam int unsigned SEG_W = 9;
  localparam int unsigned PRD_W = 2 * SEG_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRACK_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP   = 3'd4;

  localparam logic [LUX_W-1:0] CHANGE_THR_RST  = 16'd77;
  localparam logic [LUX_W-1:0] RETRACK_THR_RST = 16'd51;
  localparam logic [LUX_W-1:0] DEBOUNCE_RST    = 16'd2000;
  localparam logic [BRT_W-1:0] DEADBAND_RST    = 11'd10;
  localparam logic [BRT_W-1:0] RAMP_STEP_RST   = 11'd102;

  // request kinds on the input tuser
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef struct packed {
    logic             flat;
    logic [BRT_W-1:0] base;
    logic [SEG_W-1:0] dx;
    logic [SEG_W-1:0] mul;
    logic [DVS_W-1:0] den;
  } curve_seg_t;

  // six-segment lux to brightness curve, x in Q8.8
  function automatic curve_seg_t curve_seg(input logic [LUX_W-1:0] x);
    curve_seg_t s;
    s = '{flat: 1'b1, base: 11'd1024, dx: '0, mul: '0, den: 9'd1};
    if (x < 16'd128) begin
      s.base = 11'd102;
    end else if (x < 16'd307) begin
      s = '{flat: 1'b0, base: 11'd102, dx: SEG_W'(x - 16'd128), mul: 9'd308, den: 9'd179};
    end else if (x < 16'd589) begin
      s = '{flat: 1'b0, base: 11'd410, dx: SEG_W'(x - 16'd307), mul: 9'd307, den: 9'd282};
    end else if (x < 16'd896) begin
      s = '{flat: 1'b0, base: 11'd717, dx: SEG_W'(x - 16'd589), mul: 9'd205, den: 9'd307};
    end else if (x < 16'd1024) begin
      s.base = 11'd973;
    end
    return s;
  endfunction

  function automatic logic [LUX_W-1:0] abs_diff(input logic [LUX_W-1:0] a,
                                                input logic [LUX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage

// File: hdl/albt_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module albt_div import albt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] num_q, num_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, num_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DVS_W'(trial - {1'b0, den_q}) : DVS_W'(trial);
      num_d = {num_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while still busy");
  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider busy with zero count");
`endif

endmodule

// File: hdl/albt_win.sv
// sliding window of lux samples with running sum and fill count
module albt_win import albt_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  logic [LUX_W-1:0]                  lux_i,
  output logic [SUM_W-1:0]                  sum_o,
  output logic [$clog2(WINDOW_LEN + 1)-1:0] count_o
);

  localparam int unsigned CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  logic [LUX_W-1:0]  win_q [WINDOW_LEN];
  logic [CNT_W-1:0]  count_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SUM_W-1:0]  sum_q;
  logic              full;

  assign full = count_q == CNT_W'(WINDOW_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      slot_q  <= '0;
      sum_q   <= '0;
    end else if (push_i) begin
      if (full) begin
        sum_q <= sum_q - SUM_W'(win_q[slot_q]) + SUM_W'(lux_i);
      end else begin
        sum_q   <= sum_q + SUM_W'(lux_i);
        count_q <= count_q + 1'b1;
      end
      slot_q <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      win_q[slot_q] <= lux_i;
    end
  end

  assign sum_o   = sum_q;
  assign count_o = count_q;

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(WINDOW_LEN)) else $error("window count overflow");
  a_slot_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(slot_q) < CNT_W'(WINDOW_LEN)) else $error("write slot out of range");
  a_fill_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> CNT_W'(slot_q) == count_q) else $error("slot and count disagree while filling");
`endif

endmodule

// File: hdl/ambient_light_backlight_tracker.sv
// Ambient light backlight tracker. A lux sample transfer (tuser 0) updates the window
// on acceptance; ST_MSTART then starts the divider, ST_MWAIT waits for the bit-serial
// mean division, and the debounce state is updated when the quotient arrives, after
// which the input is ready again. A tick transfer (tuser 1) leaves the input ready,
// except the tick that expires the debounce timer: it maps the applied level through
// the brightness curve, which on a sloped segment takes a registered multiply and the
// same divider, and on a flat segment goes straight to the deadband compare. A ramp
// command is held in an output register, so a new transfer is taken while it waits;
// only a second command stalls until the first is taken.
module ambient_light_backlight_tracker import albt_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,  // lux_sample[15:0], panel_brightness[26:16]
  input  logic                  s_axis_tuser,  // req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,  // ramp_begin[10:0], ramp_target[21:11],
                                               // ramp_increment[33:22]
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MSTART = 3'd1;
  localparam logic [2:0] ST_MWAIT  = 3'd2;
  localparam logic [2:0] ST_CMUL   = 3'd3;
  localparam logic [2:0] ST_CSTART = 3'd4;
  localparam logic [2:0] ST_CWAIT  = 3'd5;
  localparam logic [2:0] ST_CCMP   = 3'd6;

  logic [2:0] state_q;

  logic [LUX_W-1:0] change_thr_q, retrack_thr_q, debounce_q;
  logic [BRT_W-1:0] deadband_q, ramp_step_q;

  logic [LUX_W-1:0] applied_q, pending_q, timer_q;
  logic             armed_q;

  logic [BRT_W-1:0] panel_q, base_q, target_q;
  logic [PRD_W-1:0] prod_q;

  logic             out_valid_q;
  logic [BRT_W-1:0] out_begin_q, out_target_q;
  logic [INC_W-1:0] out_inc_q;

  logic             in_fire, out_fire, push, load_out;
  logic             in_req;
  logic [LUX_W-1:0] in_lux;
  logic [BRT_W-1:0] in_panel;

  logic [SUM_W-1:0] win_sum;
  logic [CNT_W-1:0] win_count;

  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dividend, div_quot;
  logic [DVS_W-1:0] div_divisor;

  curve_seg_t       seg;
  logic [LUX_W-1:0] mean;
  logic [LUX_W-1:0] debounce_load;
  logic             go_up, go_down;
  logic [INC_W-1:0] inc;

  assign in_req   = s_axis_tuser;
  assign in_lux   = s_axis_tdata[15:0];
  assign in_panel = s_axis_tdata[26:16];

  assign s_axis_tready = state_q == ST_IDLE;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign push          = in_fire && (in_req == REQ_SAMPLE);

  albt_win #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_win (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .lux_i   (in_lux),
    .sum_o   (win_sum),
    .count_o (win_count)
  );

  assign div_start    = (state_q == ST_MSTART) || (state_q == ST_CSTART);
  assign div_dividend = (state_q == ST_MSTART) ? DIV_W'(win_sum) : DIV_W'(prod_q);
  assign div_divisor  = (state_q == ST_MSTART) ? DVS_W'(win_count) : seg.den;

  albt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign seg           = curve_seg(applied_q);
  assign mean          = div_quot[LUX_W-1:0];
  assign debounce_load = (debounce_q == '0) ? LUX_W'(1) : debounce_q;

  // deadband compare with one guard bit so the sums cannot wrap
  assign go_up   = {1'b0, target_q} > ({1'b0, panel_q} + {1'b0, deadband_q});
  assign go_down = {1'b0, panel_q} > ({1'b0, target_q} + {1'b0, deadband_q});
  assign inc     = go_up ? {1'b0, ramp_step_q} : (~{1'b0, ramp_step_q}) + 1'b1;

  assign load_out = (state_q == ST_CCMP) && (go_up || go_down) &&
                    (!out_valid_q || m_axis_tready);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      change_thr_q  <= CHANGE_THR_RST;
      retrack_thr_q <= RETRACK_THR_RST;
      debounce_q    <= DEBOUNCE_RST;
      deadband_q    <= DEADBAND_RST;
      ramp_step_q   <= RAMP_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CHANGE_THR:  change_thr_q  <= cfg_data_i;
        CFG_RETRACK_THR: retrack_thr_q <= cfg_data_i;
        CFG_DEBOUNCE:    debounce_q    <= cfg_data_i;
        CFG_DEADBAND:    deadband_q    <= cfg_data_i[BRT_W-1:0];
        CFG_RAMP_STEP:   ramp_step_q   <= cfg_data_i[BRT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      applied_q   <= '0;
      pending_q   <= '0;
      timer_q     <= '0;
      armed_q     <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_req == REQ_SAMPLE) begin
              state_q <= ST_MSTART;
            end else if (armed_q) begin
              if (timer_q > LUX_W'(1)) begin
                timer_q <= timer_q - 1'b1;
              end else begin
                timer_q   <= '0;
                armed_q   <= 1'b0;
                applied_q <= pending_q;
                state_q   <= ST_CMUL;
              end
            end
          end
        end
        ST_MSTART: state_q <= ST_MWAIT;
        ST_MWAIT: begin
          if (div_done) begin
            state_q <= ST_IDLE;
            if (abs_diff(applied_q, mean) > change_thr_q) begin
              if (!armed_q || (abs_diff(pending_q, mean) > retrack_thr_q)) begin
                pending_q <= mean;
                timer_q   <= debounce_load;
                armed_q   <= 1'b1;
              end
            end else begin
              armed_q <= 1'b0;
              timer_q <= '0;
            end
          end
        end
        ST_CMUL:   state_q <= seg.flat ? ST_CCMP : ST_CSTART;
        ST_CSTART: state_q <= ST_CWAIT;
        ST_CWAIT: begin
          if (div_done) begin
            state_q <= ST_CCMP;
          end
        end
        ST_CCMP: begin
          if (!go_up && !go_down) begin
            state_q <= ST_IDLE;
          end else if (!out_valid_q || m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // output register, a new command may replace one that leaves in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      panel_q <= in_panel;
    end
    if (state_q == ST_CMUL) begin
      prod_q   <= PRD_W'(seg.dx) * PRD_W'(seg.mul);
      base_q   <= seg.base;
      target_q <= seg.base;
    end
    if ((state_q == ST_CWAIT) && div_done) begin
      target_q <= base_q + div_quot[BRT_W-1:0];
    end
    if (load_out) begin
      out_begin_q  <= panel_q;
      out_target_q <= target_q;
      out_inc_q    <= inc;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_inc_q, out_target_q, out_begin_q};

`ifndef SYNTH
  a_armed_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> timer_q != '0) else $error("armed timer with zero count");
  a_disarmed_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |-> timer_q == '0) else $error("disarmed timer not cleared");
  a_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_MWAIT) || (state_q == ST_CWAIT))
    else $error("divider result arrived outside a wait state");
  a_expire_curve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMUL) |-> applied_q == pending_q)
    else $error("curve evaluated on a level other than the pending one");
`endif

endmodule
